// ===== rtl/crms_pkg.sv =====
// Shared constants and controller/datapath interface types for the chunk RMS meter.
`default_nettype none

package crms_pkg;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEREO_MODE  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_LIMIT  = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] CHUNK_LENGTH_RESET = 16'd10000;
  localparam logic                     STEREO_MODE_RESET  = 1'b1;
  localparam logic [CFG_DATA_BITS-1:0] CHUNK_LIMIT_RESET  = 16'd1024;

  typedef struct packed {
    logic capture;     // latch the accepted sample pair
    logic square;      // register the squared mono magnitude
    logic accum;       // update sums and counts, load the divider
    logic div_step;    // one restoring division step
    logic sqrt_start;  // load the root unit from the quotient
    logic sqrt_step;   // one root digit step
    logic out_load;    // move the root into the output register
  } crms_cmd_t;

  typedef struct packed {
    logic take_result; // the accumulated sample closes a chunk or flushes
    logic div_last;    // the current division step is the final one
    logic sqrt_last;   // the current root step is the final one
  } crms_stat_t;

endpackage

`default_nettype wire

// ===== rtl/chunk_rms_envelope.sv =====
// Top level of the chunk RMS level meter: controller plus datapath.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o   left_sample_i, right_sample_i, end_of_stream_i
//   out      source     out_valid_o/out_stall_i rms_level_o, is_flush_o
//   cfg      sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// A sample that closes no chunk passes through capture, square and accumulate.
// A sample that yields a result adds ACC_BITS division steps, the root load,
// ROOT_BITS root steps and the output load, which waits while the output stalls.
// The serial divider (one quotient bit per cycle) is the longest part of that work.
// Reset clears configuration to its defaults, empties sums and counts and clears out_valid_o.
// A stalled output holds its result; the next sample is taken meanwhile.
`default_nettype none

module chunk_rms_envelope #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [crms_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire  [crms_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  signed [SAMPLE_BITS-1:0]        left_sample_i,
  input  wire  signed [SAMPLE_BITS-1:0]        right_sample_i,
  input  wire                                  end_of_stream_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic [SAMPLE_BITS-1:0]               rms_level_o,
  output logic                                 is_flush_o
);

  crms_pkg::crms_cmd_t  cmd;
  crms_pkg::crms_stat_t stat;

  crms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crms_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .end_of_stream_i (end_of_stream_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .rms_level_o     (rms_level_o),
    .is_flush_o      (is_flush_o)
  );

endmodule

`default_nettype wire

// ===== rtl/crms_datapath.sv =====
// Datapath: config registers, accumulator, serial divider, serial square root, output payload.
`default_nettype none

module crms_datapath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_we_i,
  input  wire  [crms_pkg::CFG_INDEX_BITS-1:0]      cfg_index_i,
  input  wire  [crms_pkg::CFG_DATA_BITS-1:0]       cfg_data_i,
  input  wire  signed [SAMPLE_BITS-1:0]            left_sample_i,
  input  wire  signed [SAMPLE_BITS-1:0]            right_sample_i,
  input  wire                                      end_of_stream_i,
  input  wire  crms_pkg::crms_cmd_t                cmd_i,
  output crms_pkg::crms_stat_t                     stat_o,
  output logic [SAMPLE_BITS-1:0]                   rms_level_o,
  output logic                                     is_flush_o
);

  localparam int unsigned MAG_BITS  = SAMPLE_BITS + 1;
  localparam int unsigned PROD_BITS = 2 * MAG_BITS;
  localparam int unsigned ACC_BITS  = (PROD_BITS + COUNT_BITS > 64) ? 64
                                                                     : PROD_BITS + COUNT_BITS;
  localparam int unsigned RAD_BITS  = ACC_BITS - 2;
  localparam int unsigned ROOT_BITS = (RAD_BITS + 1) / 2;
  localparam int unsigned X_BITS    = 2 * ROOT_BITS;
  localparam int unsigned STEP_BITS = $clog2(ACC_BITS);
  localparam int unsigned LEN_BITS  = (COUNT_BITS > crms_pkg::CFG_DATA_BITS) ? COUNT_BITS
                                                                        : crms_pkg::CFG_DATA_BITS;
  localparam logic [LEN_BITS-1:0]  CNT_MAX_W = LEN_BITS'({COUNT_BITS{1'b1}});
  localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(ACC_BITS - 1);
  localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(ROOT_BITS - 1);

  // configuration
  logic [crms_pkg::CFG_DATA_BITS-1:0] length_q, limit_q;
  logic                               stereo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= crms_pkg::CHUNK_LENGTH_RESET;
      stereo_q <= crms_pkg::STEREO_MODE_RESET;
      limit_q  <= crms_pkg::CHUNK_LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        crms_pkg::CFG_CHUNK_LENGTH: length_q <= cfg_data_i;
        crms_pkg::CFG_STEREO_MODE:  stereo_q <= cfg_data_i[0];
        crms_pkg::CFG_CHUNK_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sample capture and squaring
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;
  logic                          eos_q;
  logic signed [MAG_BITS-1:0]    mono;
  logic        [MAG_BITS-1:0]    mag;
  logic        [PROD_BITS-1:0]   sq_q;

  assign mono = stereo_q ? (MAG_BITS'(left_q) + MAG_BITS'(right_q))
                         : (MAG_BITS'(left_q) <<< 1);
  assign mag  = mono[MAG_BITS-1] ? MAG_BITS'(-mono) : MAG_BITS'(mono);

  // accumulator and counters
  logic [ACC_BITS-1:0]   sum_q, sum_nx;
  logic [ACC_BITS:0]     sum_wide;
  logic [COUNT_BITS-1:0] cnt_q, cnt_nx, chunks_q, chunks_nx;
  logic [LEN_BITS-1:0]   len_raw, len_eff;
  logic                  emit, flush;

  assign sum_wide  = {1'b0, sum_q} + (ACC_BITS + 1)'(sq_q);
  assign sum_nx    = sum_wide[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_wide[ACC_BITS-1:0];
  assign cnt_nx    = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
  assign chunks_nx = (chunks_q == {COUNT_BITS{1'b1}}) ? chunks_q : chunks_q + 1'b1;

  // zero length acts as one, lengths beyond the counter range clamp to its maximum
  assign len_raw = (length_q == '0) ? LEN_BITS'(1) : LEN_BITS'(length_q);
  assign len_eff = (len_raw > CNT_MAX_W) ? CNT_MAX_W : len_raw;
  assign emit    = LEN_BITS'(cnt_nx) >= len_eff;
  // without an emit the chunk always holds the sample just added
  assign flush   = eos_q && !emit && (LEN_BITS'(chunks_q) < LEN_BITS'(limit_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      chunks_q <= '0;
    end else if (cmd_i.accum) begin
      if (eos_q) begin
        sum_q    <= '0;
        cnt_q    <= '0;
        chunks_q <= '0;
      end else if (emit) begin
        sum_q    <= '0;
        cnt_q    <= '0;
        chunks_q <= chunks_nx;
      end else begin
        sum_q <= sum_nx;
        cnt_q <= cnt_nx;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [ACC_BITS-1:0]   quo_q;
  logic [COUNT_BITS-1:0] div_q, drem_q;
  logic [COUNT_BITS:0]   drem_sh;
  logic [COUNT_BITS+1:0] ddiff;
  logic [STEP_BITS-1:0]  step_q;
  logic                  res_flush_q;

  assign drem_sh = {drem_q, quo_q[ACC_BITS-1]};
  assign ddiff   = {1'b0, drem_sh} - {2'b00, div_q};

  // bit-pair square root
  logic [X_BITS-1:0]    x_q;
  logic [ROOT_BITS-1:0] root_q;
  logic [ROOT_BITS:0]   srem_q;
  logic [ROOT_BITS+2:0] srem_sh;
  logic [ROOT_BITS+3:0] sdiff;

  assign srem_sh = {srem_q, x_q[X_BITS-1 -: 2]};
  assign sdiff   = {1'b0, srem_sh} - {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      left_q  <= left_sample_i;
      right_q <= right_sample_i;
      eos_q   <= end_of_stream_i;
    end
    if (cmd_i.square) begin
      sq_q <= PROD_BITS'(mag) * PROD_BITS'(mag);
    end
    if (cmd_i.accum) begin
      quo_q       <= sum_nx;
      div_q       <= cnt_nx;
      drem_q      <= '0;
      step_q      <= '0;
      res_flush_q <= !emit;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[ACC_BITS-2:0], !ddiff[COUNT_BITS+1]};
      drem_q <= ddiff[COUNT_BITS+1] ? drem_sh[COUNT_BITS-1:0] : ddiff[COUNT_BITS-1:0];
      step_q <= step_q + 1'b1;
    end else if (cmd_i.sqrt_start) begin
      x_q    <= X_BITS'(quo_q >> 2);
      root_q <= '0;
      srem_q <= '0;
      step_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      x_q    <= x_q << 2;
      root_q <= {root_q[ROOT_BITS-2:0], !sdiff[ROOT_BITS+3]};
      srem_q <= sdiff[ROOT_BITS+3] ? srem_sh[ROOT_BITS:0] : sdiff[ROOT_BITS:0];
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      rms_level_o <= root_q[SAMPLE_BITS-1:0];
      is_flush_o  <= res_flush_q;
    end
  end

  assign stat_o.take_result = emit || flush;
  assign stat_o.div_last    = (step_q == DIV_LAST);
  assign stat_o.sqrt_last   = (step_q == SQRT_LAST);

endmodule

`default_nettype wire

// ===== rtl/crms_ctrl.sv =====
// Controller: sequences capture, squaring, accumulation, division, root and output handoff.
`default_nettype none

module crms_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  input  wire crms_pkg::crms_stat_t stat_i,
  output crms_pkg::crms_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_ACC    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_SQLOAD = 3'd4;
  localparam logic [2:0] ST_SQRT   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.square = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        state_d     = stat_i.take_result ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_SQLOAD;
      end
      ST_SQLOAD: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (stat_i.sqrt_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (!out_stall_i)       out_valid_d = 1'b0;
    else                         out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
